@@ hw/rtl/rtch_pkg.sv @@
package rtch_pkg;

   localparam int CoordW   = 32;
   localparam int DistW    = 31;
   localparam int IdxW     = 16;
   localparam int WideW    = CoordW + 1;      // vertex differences
   localparam int HqW      = 67;              // cross product terms
   localparam int AccW     = 104;             // dot products, exact
   localparam int TermW    = 5;
   localparam int BitW     = 6;
   localparam int CsrIdxW  = 3;
   localparam int DivSteps = DistW;

   localparam logic [TermW-1:0] TERM_LAST = 5'd23;
   localparam logic [BitW-1:0]  MUL_LAST  = BitW'(WideW - 1);
   localparam logic [BitW-1:0]  DIV_LAST  = BitW'(DivSteps - 1);
   localparam logic [DistW-1:0] DIST_MAX  = '1;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_MAX_DIST = 3'd6;

   // multiplicand sources (wide side)
   localparam logic [3:0] X_D = 4'd0;
   localparam logic [3:0] X_S = 4'd3;
   localparam logic [3:0] X_H = 4'd6;
   localparam logic [3:0] X_Q = 4'd9;
   // multiplier sources (serial side)
   localparam logic [3:0] Y_E1 = 4'd0;
   localparam logic [3:0] Y_E2 = 4'd3;
   localparam logic [3:0] Y_S  = 4'd6;
   localparam logic [3:0] Y_D  = 4'd9;
   // destinations
   localparam logic [3:0] DST_H = 4'd0;
   localparam logic [3:0] DST_Q = 4'd3;
   localparam logic [3:0] DST_A = 4'd6;
   localparam logic [3:0] DST_U = 4'd7;
   localparam logic [3:0] DST_V = 4'd8;
   localparam logic [3:0] DST_N = 4'd9;

   typedef struct packed {
      logic signed [CoordW-1:0] vertex0_x;
      logic signed [CoordW-1:0] vertex0_y;
      logic signed [CoordW-1:0] vertex0_z;
      logic signed [CoordW-1:0] vertex1_x;
      logic signed [CoordW-1:0] vertex1_y;
      logic signed [CoordW-1:0] vertex1_z;
      logic signed [CoordW-1:0] vertex2_x;
      logic signed [CoordW-1:0] vertex2_y;
      logic signed [CoordW-1:0] vertex2_z;
      logic                     last_triangle;
   } req_item_type;

   typedef struct packed {
      logic             hit;
      logic [DistW-1:0] hit_distance;
      logic             nearest_found;
      logic [DistW-1:0] nearest_distance;
      logic [IdxW-1:0]  nearest_index;
      logic             occluded;
   } rsp_item_type;

   typedef logic [2:0][CoordW-1:0] vec3_type;
   typedef logic [2:0][WideW-1:0]  wvec3_type;

   typedef struct packed {
      wvec3_type e1;
      wvec3_type e2;
      wvec3_type s;
      logic      last;
   } tri_type;

   typedef struct packed {
      logic             hit;
      logic [DistW-1:0] t_dist;
      logic             last;
   } eng_res_type;

   typedef struct packed {
      logic [3:0] xsel;
      logic [3:0] ysel;
      logic       neg;
      logic       close;
      logic [3:0] dest;
   } term_type;

   // h = d x e2, a = e1.h, u = s.h, q = s x e1, v = d.q, n = e2.q
   function automatic term_type term_info(input logic [TermW-1:0] idx);
      term_type t;
      t = '{xsel: X_D, ysel: Y_E1, neg: 1'b0, close: 1'b0, dest: DST_A};
      case (idx)
         5'd0:  t = '{X_D + 4'd1, Y_E2 + 4'd2, 1'b0, 1'b0, DST_H};
         5'd1:  t = '{X_D + 4'd2, Y_E2 + 4'd1, 1'b1, 1'b1, DST_H};
         5'd2:  t = '{X_D + 4'd2, Y_E2,        1'b0, 1'b0, DST_H + 4'd1};
         5'd3:  t = '{X_D,        Y_E2 + 4'd2, 1'b1, 1'b1, DST_H + 4'd1};
         5'd4:  t = '{X_D,        Y_E2 + 4'd1, 1'b0, 1'b0, DST_H + 4'd2};
         5'd5:  t = '{X_D + 4'd1, Y_E2,        1'b1, 1'b1, DST_H + 4'd2};
         5'd6:  t = '{X_H,        Y_E1,        1'b0, 1'b0, DST_A};
         5'd7:  t = '{X_H + 4'd1, Y_E1 + 4'd1, 1'b0, 1'b0, DST_A};
         5'd8:  t = '{X_H + 4'd2, Y_E1 + 4'd2, 1'b0, 1'b1, DST_A};
         5'd9:  t = '{X_H,        Y_S,         1'b0, 1'b0, DST_U};
         5'd10: t = '{X_H + 4'd1, Y_S + 4'd1,  1'b0, 1'b0, DST_U};
         5'd11: t = '{X_H + 4'd2, Y_S + 4'd2,  1'b0, 1'b1, DST_U};
         5'd12: t = '{X_S + 4'd1, Y_E1 + 4'd2, 1'b0, 1'b0, DST_Q};
         5'd13: t = '{X_S + 4'd2, Y_E1 + 4'd1, 1'b1, 1'b1, DST_Q};
         5'd14: t = '{X_S + 4'd2, Y_E1,        1'b0, 1'b0, DST_Q + 4'd1};
         5'd15: t = '{X_S,        Y_E1 + 4'd2, 1'b1, 1'b1, DST_Q + 4'd1};
         5'd16: t = '{X_S,        Y_E1 + 4'd1, 1'b0, 1'b0, DST_Q + 4'd2};
         5'd17: t = '{X_S + 4'd1, Y_E1,        1'b1, 1'b1, DST_Q + 4'd2};
         5'd18: t = '{X_Q,        Y_D,         1'b0, 1'b0, DST_V};
         5'd19: t = '{X_Q + 4'd1, Y_D + 4'd1,  1'b0, 1'b0, DST_V};
         5'd20: t = '{X_Q + 4'd2, Y_D + 4'd2,  1'b0, 1'b1, DST_V};
         5'd21: t = '{X_Q,        Y_E2,        1'b0, 1'b0, DST_N};
         5'd22: t = '{X_Q + 4'd1, Y_E2 + 4'd1, 1'b0, 1'b0, DST_N};
         5'd23: t = '{X_Q + 4'd2, Y_E2 + 4'd2, 1'b0, 1'b1, DST_N};
         default: t = '{X_D, Y_E1, 1'b0, 1'b0, DST_A};
      endcase
      return t;
   endfunction

endpackage

@@ hw/rtl/rtch_front.sv @@
module rtch_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  rtch_pkg::req_item_type req_item,
   output logic                  req_full,
   input  rtch_pkg::vec3_type    origin,
   output logic                  tri_valid,
   input  logic                  tri_pop,
   output rtch_pkg::tri_type     tri_out
);
   import rtch_pkg::*;

   tri_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   tri_type    entry;
   logic       push_ok, pop_ok;
   vec3_type   v0, v1, v2;

   assign v0 = {req_item.vertex0_z, req_item.vertex0_y, req_item.vertex0_x};
   assign v1 = {req_item.vertex1_z, req_item.vertex1_y, req_item.vertex1_x};
   assign v2 = {req_item.vertex2_z, req_item.vertex2_y, req_item.vertex2_x};

   // edge and origin offsets, exact in one extra bit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         entry.e1[i] = {v1[i][CoordW-1], v1[i]} - {v0[i][CoordW-1], v0[i]};
         entry.e2[i] = {v2[i][CoordW-1], v2[i]} - {v0[i][CoordW-1], v0[i]};
         entry.s[i]  = {origin[i][CoordW-1], origin[i]} - {v0[i][CoordW-1], v0[i]};
      end
      entry.last = req_item.last_triangle;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign tri_valid = (cnt_ff != 2'd0);
   assign tri_out   = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = tri_pop && tri_valid;

   always_comb begin
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = pop_ok ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= entry;
      end
   end

endmodule

@@ hw/rtl/rtch_engine.sv @@
module rtch_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  rtch_pkg::vec3_type    dir,
   input  logic                  tri_valid,
   input  rtch_pkg::tri_type     tri_in,
   output logic                  tri_pop,
   output logic                  res_valid,
   output rtch_pkg::eng_res_type res_item,
   input  logic                  res_ready
);
   import rtch_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_FLIP  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   tri_type               tri_ff;
   logic [2:0][HqW-1:0]   h_ff, q_ff;
   logic [AccW-1:0]       a_ff, u_ff, v_ff, n_ff;
   logic [AccW-1:0]       acc_ff, xs_ff, r_ff;
   logic [WideW-1:0]      yb_ff;
   logic [DistW-1:0]      xl_ff, qt_ff;
   logic [BitW-1:0]       bit_ff;
   logic [TermW-1:0]      term_ff;
   logic                  hit_ff;
   logic [DistW-1:0]      dist_ff;

   term_type              ti;
   logic [AccW-1:0]       xval;
   logic [WideW-1:0]      yval;
   logic                  sub;
   logic [AccW-1:0]       addend, acc_nx;
   logic [AccW-1:0]       a_m_u, a_m_uv;
   logic                  ok, sat;
   logic [AccW:0]         rs, rdiff;
   logic [DistW-1:0]      qt_nx;

   assign ti = term_info(term_ff);

   always_comb begin
      xval = '0;
      unique case (ti.xsel)
         X_D:        xval = AccW'(signed'(dir[0]));
         X_D + 4'd1: xval = AccW'(signed'(dir[1]));
         X_D + 4'd2: xval = AccW'(signed'(dir[2]));
         X_S:        xval = AccW'(signed'(tri_ff.s[0]));
         X_S + 4'd1: xval = AccW'(signed'(tri_ff.s[1]));
         X_S + 4'd2: xval = AccW'(signed'(tri_ff.s[2]));
         X_H:        xval = AccW'(signed'(h_ff[0]));
         X_H + 4'd1: xval = AccW'(signed'(h_ff[1]));
         X_H + 4'd2: xval = AccW'(signed'(h_ff[2]));
         X_Q:        xval = AccW'(signed'(q_ff[0]));
         X_Q + 4'd1: xval = AccW'(signed'(q_ff[1]));
         X_Q + 4'd2: xval = AccW'(signed'(q_ff[2]));
         default:    xval = '0;
      endcase
   end

   always_comb begin
      yval = '0;
      unique case (ti.ysel)
         Y_E1:        yval = tri_ff.e1[0];
         Y_E1 + 4'd1: yval = tri_ff.e1[1];
         Y_E1 + 4'd2: yval = tri_ff.e1[2];
         Y_E2:        yval = tri_ff.e2[0];
         Y_E2 + 4'd1: yval = tri_ff.e2[1];
         Y_E2 + 4'd2: yval = tri_ff.e2[2];
         Y_S:         yval = tri_ff.s[0];
         Y_S + 4'd1:  yval = tri_ff.s[1];
         Y_S + 4'd2:  yval = tri_ff.s[2];
         Y_D:         yval = {dir[0][CoordW-1], dir[0]};
         Y_D + 4'd1:  yval = {dir[1][CoordW-1], dir[1]};
         Y_D + 4'd2:  yval = {dir[2][CoordW-1], dir[2]};
         default:     yval = '0;
      endcase
   end

   // serial signed multiply: the multiplier's sign bit carries negative weight
   always_comb begin
      sub    = ti.neg ^ (bit_ff == MUL_LAST);
      addend = sub ? (~xs_ff + AccW'(1)) : xs_ff;
      acc_nx = yb_ff[0] ? (acc_ff + addend) : acc_ff;
   end

   always_comb begin
      a_m_u  = a_ff - u_ff;
      a_m_uv = a_m_u - v_ff;
      ok     = (a_ff != '0) && !u_ff[AccW-1] && !a_m_u[AccW-1] && !v_ff[AccW-1]
               && !a_m_uv[AccW-1] && !n_ff[AccW-1] && (n_ff != '0);
      sat    = {15'd0, n_ff} >= {a_ff, 15'd0};
      rs     = {r_ff, xl_ff[DistW-1]};
      rdiff  = rs - {1'b0, a_ff};
      qt_nx  = {qt_ff[DistW-2:0], !rdiff[AccW]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (tri_valid) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL: begin
            if (bit_ff == MUL_LAST) begin
               state_in = (term_ff == TERM_LAST) ? ST_FLIP : ST_LOAD;
            end
         end
         ST_FLIP:  state_in = ST_CHECK;
         ST_CHECK: state_in = (ok && !sat) ? ST_DIV : ST_DONE;
         ST_DIV:   if (bit_ff == DIV_LAST) state_in = ST_DONE;
         ST_DONE:  if (res_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign tri_pop   = (state_ff == ST_IDLE) && tri_valid;
   assign res_valid = (state_ff == ST_DONE);
   assign res_item  = '{hit: hit_ff, t_dist: dist_ff, last: tri_ff.last};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            tri_ff  <= tri_in;
            term_ff <= '0;
            acc_ff  <= '0;
         end
         ST_LOAD: begin
            xs_ff  <= xval;
            yb_ff  <= yval;
            bit_ff <= '0;
         end
         ST_MUL: begin
            xs_ff  <= {xs_ff[AccW-2:0], 1'b0};
            yb_ff  <= {1'b0, yb_ff[WideW-1:1]};
            bit_ff <= bit_ff + BitW'(1);
            if ((bit_ff == MUL_LAST) && ti.close) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_nx;
            end
            if (bit_ff == MUL_LAST) begin
               term_ff <= term_ff + TermW'(1);
               if (ti.close) begin
                  case (ti.dest)
                     DST_H:        h_ff[0] <= acc_nx[HqW-1:0];
                     DST_H + 4'd1: h_ff[1] <= acc_nx[HqW-1:0];
                     DST_H + 4'd2: h_ff[2] <= acc_nx[HqW-1:0];
                     DST_Q:        q_ff[0] <= acc_nx[HqW-1:0];
                     DST_Q + 4'd1: q_ff[1] <= acc_nx[HqW-1:0];
                     DST_Q + 4'd2: q_ff[2] <= acc_nx[HqW-1:0];
                     DST_A:        a_ff    <= acc_nx;
                     DST_U:        u_ff    <= acc_nx;
                     DST_V:        v_ff    <= acc_nx;
                     DST_N:        n_ff    <= acc_nx;
                     default:      ;
                  endcase
               end
            end
         end
         ST_FLIP: begin
            // fold a negative determinant into positive form
            if (a_ff[AccW-1]) begin
               a_ff <= '0 - a_ff;
               u_ff <= '0 - u_ff;
               v_ff <= '0 - v_ff;
               n_ff <= '0 - n_ff;
            end
         end
         ST_CHECK: begin
            hit_ff  <= ok;
            dist_ff <= ok ? DIST_MAX : '0;
            r_ff    <= {15'd0, n_ff[AccW-1:15]};
            xl_ff   <= {n_ff[14:0], 16'd0};
            qt_ff   <= '0;
            bit_ff  <= '0;
         end
         ST_DIV: begin
            r_ff   <= rdiff[AccW] ? rs[AccW-1:0] : rdiff[AccW-1:0];
            xl_ff  <= {xl_ff[DistW-2:0], 1'b0};
            qt_ff  <= qt_nx;
            bit_ff <= bit_ff + BitW'(1);
            if (bit_ff == DIV_LAST) begin
               hit_ff  <= (qt_nx != '0);
               dist_ff <= qt_nx;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/rtch_track.sv @@
module rtch_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [rtch_pkg::DistW-1:0] max_distance,
   input  logic                   res_valid,
   input  rtch_pkg::eng_res_type  res_item,
   output logic                   res_ready,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rtch_pkg::rsp_item_type rsp_item
);
   import rtch_pkg::*;

   logic             full_ff;
   rsp_item_type     out_ff, out_in;
   logic [DistW-1:0] best_ff, best_in;
   logic [IdxW-1:0]  pos_ff, pos_in, cnt_ff;
   logic             found_ff, found_in, blk_ff, blk_in;
   logic             take, accept;

   assign res_ready = !full_ff || rsp_pop;
   assign accept    = res_valid && res_ready;
   assign rsp_empty = !full_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      take     = res_item.hit && (!found_ff || (res_item.t_dist < best_ff));
      best_in  = take ? res_item.t_dist : best_ff;
      pos_in   = take ? cnt_ff : pos_ff;
      found_in = found_ff || res_item.hit;
      blk_in   = blk_ff || (res_item.hit && (res_item.t_dist < max_distance));
      out_in.hit              = res_item.hit;
      out_in.hit_distance     = res_item.t_dist;
      out_in.nearest_found    = found_in;
      out_in.nearest_distance = found_in ? best_in : '0;
      out_in.nearest_index    = found_in ? pos_in : '0;
      out_in.occluded         = blk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         best_ff  <= DIST_MAX;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         blk_ff   <= 1'b0;
      end else begin
         if (accept) begin
            full_ff <= 1'b1;
         end else if (rsp_pop) begin
            full_ff <= 1'b0;
         end
         if (accept) begin
            // end of run: drop the run state
            if (res_item.last) begin
               best_ff  <= DIST_MAX;
               pos_ff   <= '0;
               cnt_ff   <= '0;
               found_ff <= 1'b0;
               blk_ff   <= 1'b0;
            end else begin
               best_ff  <= best_in;
               pos_ff   <= pos_in;
               cnt_ff   <= cnt_ff + IdxW'(1);
               found_ff <= found_in;
               blk_ff   <= blk_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ hw/rtl/ray_triangle_closest_hit.sv @@
// channel  direction  handshake              payload
// req      in         req_push / req_full    req_item  (one triangle)
// rsp      out        rsp_pop / rsp_empty    rsp_item  (test and run result)
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// An item passes through the serial multiply-accumulate unit: a pop step, then
// a load step and 33 multiplier bits for each of the 24 terms, then flip, check
// and done, plus a restoring division for the 31 quotient bits when the triangle
// is hit and the distance does not saturate.
// A two-item queue holds triangles while the engine works; one result register
// holds the answer until popped, and the engine waits in its done state meanwhile.
// Reset is synchronous and restores the ray registers and the run state.
module ray_triangle_closest_hit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  rtch_pkg::req_item_type        req_item,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output rtch_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtch_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rtch_pkg::CoordW-1:0]   csr_data
);
   import rtch_pkg::*;

   vec3_type         origin_ff, dir_ff;
   logic [DistW-1:0] maxd_ff;
   logic             tri_valid, tri_pop, res_valid, res_ready;
   tri_type          tri_item;
   eng_res_type      res_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         dir_ff    <= {CoordW'(65536), CoordW'(0), CoordW'(0)};
         maxd_ff   <= DIST_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= csr_data;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_data;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_data;
            CSR_DIR_X:    dir_ff[0]    <= csr_data;
            CSR_DIR_Y:    dir_ff[1]    <= csr_data;
            CSR_DIR_Z:    dir_ff[2]    <= csr_data;
            CSR_MAX_DIST: maxd_ff      <= csr_data[DistW-1:0];
            default:      ;
         endcase
      end
   end

   rtch_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .origin    (origin_ff),
      .tri_valid (tri_valid),
      .tri_pop   (tri_pop),
      .tri_out   (tri_item)
   );

   rtch_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .dir       (dir_ff),
      .tri_valid (tri_valid),
      .tri_in    (tri_item),
      .tri_pop   (tri_pop),
      .res_valid (res_valid),
      .res_item  (res_item),
      .res_ready (res_ready)
   );

   rtch_track u_track (
      .clock        (clock),
      .reset        (reset),
      .max_distance (maxd_ff),
      .res_valid    (res_valid),
      .res_item     (res_item),
      .res_ready    (res_ready),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_item     (rsp_item)
   );

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full)) else $error("queues not empty after reset");

   a_hit_sets_found: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.hit) |-> rsp_item.nearest_found)
      else $error("hit without nearest");

   a_nearest_le_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.hit) |->
      (rsp_item.nearest_distance <= rsp_item.hit_distance))
      else $error("nearest farther than current hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.hit) |-> (rsp_item.hit_distance == '0))
      else $error("miss with nonzero distance");

endmodule
